### hdl/wtl_pkg.sv
`timescale 1ns / 1ps

package wtl_pkg;

  localparam int RowBits     = 4;
  localparam int ColBits     = 10;
  localparam int AddrBits    = RowBits + ColBits;
  localparam int SampleBits  = 16;
  localparam int RowCntBits  = 5;
  localparam int ColCntBits  = 11;
  localparam int ColIdxBits  = 19;
  localparam int AccBits     = 42;
  localparam int FracBits    = 16;
  localparam int MagBits     = 18;
  localparam int DivBits     = 12;

  localparam logic [RowCntBits-1:0] RowsMax = 5'd16;
  localparam logic [ColCntBits-1:0] ColsMax = 11'd1024;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  typedef enum logic {
    INTERP_LINEAR = 1'b0,
    INTERP_CUBIC  = 1'b1
  } interp_e;

  typedef enum logic [1:0] {
    WRAP_WRAP   = 2'd0,
    WRAP_BOUNCE = 2'd1,
    WRAP_ZERO   = 2'd2,
    WRAP_CLAMP  = 2'd3
  } wrap_e;

  typedef enum logic [1:0] {
    REG_INTERP = 2'd0,
    REG_WRAP   = 2'd1,
    REG_ROWS   = 2'd2,
    REG_COLS   = 2'd3
  } reg_e;

  typedef struct packed {
    op_e                           opcode;
    logic [15:0]                   row_position;
    logic signed [23:0]            column_phase;
    logic [RowBits-1:0]            entry_row;
    logic [ColBits-1:0]            entry_column;
    logic signed [SampleBits-1:0]  entry_value;
  } wtl_req_t;

  typedef struct packed {
    logic signed [SampleBits-1:0]  sample_out;
    logic                          saturated;
  } wtl_rsp_t;

  // Effective configuration, counts already limited to the table size.
  typedef struct packed {
    interp_e                 interp;
    wrap_e                   wrap;
    logic [RowCntBits-1:0]   rows;
    logic [ColCntBits-1:0]   cols;
  } wtl_cfg_t;

  typedef struct packed {
    logic                          is_write;
    logic [RowBits-1:0]            entry_row;
    logic [ColBits-1:0]            entry_column;
    logic signed [SampleBits-1:0]  entry_value;
    logic [RowBits-1:0]            row1;
    logic [RowBits-1:0]            row2;
    logic [FracBits-1:0]           rr;
    logic [FracBits-1:0]           t;
    logic signed [ColIdxBits-1:0]  col;
    logic [ColCntBits-1:0]         base;
  } wtl_job_t;

endpackage

### hdl/wtl_front.sv
`timescale 1ns / 1ps

module wtl_front import wtl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wtl_cfg_t cfg_i,
  input  logic     push,
  output logic     full,
  input  wtl_req_t req_i,
  output wtl_job_t job_o,
  output logic     job_valid_o,
  input  logic     job_ready_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  wtl_job_t job_q, job_d;
  logic [MagBits-1:0] mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [DivBits-1:0] div_q, div_d;
  logic [DivBits-1:0] rem_q, rem_d;
  logic [4:0]         cnt_q, cnt_d;

  logic signed [34:0]           prod;
  logic [20:0]                  rp;
  logic [RowBits-1:0]           row1;
  logic signed [ColIdxBits-1:0] col_new;
  logic signed [ColIdxBits-1:0] col_neg;
  logic [DivBits-1:0]           rem_s;
  logic [DivBits-1:0]           rem_n;
  logic [DivBits-1:0]           base_w;
  logic                         need_div;

  assign full        = (state_q != F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

  assign prod    = $signed(req_i.column_phase) * $signed({1'b0, cfg_i.cols});
  assign rp      = 21'(req_i.row_position) * 21'(cfg_i.rows);
  assign row1    = rp[19:16];
  assign col_new = prod[34:16];
  assign col_neg = -col_new;

  assign need_div = (req_i.opcode == OP_LOOKUP) && (cfg_i.cols != 11'd1) &&
                    ((cfg_i.wrap == WRAP_WRAP) || (cfg_i.wrap == WRAP_BOUNCE));

  // One bit of restoring remainder per cycle.
  assign rem_s  = {rem_q[DivBits-2:0], mag_q[MagBits-1]};
  assign rem_n  = (rem_s >= div_q) ? (rem_s - div_q) : rem_s;
  assign base_w = (neg_q && (rem_n != '0)) ? (div_q - rem_n) : rem_n;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (push) begin
          job_d.is_write     = (req_i.opcode == OP_WRITE);
          job_d.entry_row    = req_i.entry_row;
          job_d.entry_column = req_i.entry_column;
          job_d.entry_value  = req_i.entry_value;
          job_d.row1         = row1;
          job_d.row2         = (({1'b0, row1} + 5'd1) == cfg_i.rows) ? '0 : (row1 + 4'd1);
          job_d.rr           = rp[15:0];
          job_d.t            = prod[15:0];
          job_d.col          = col_new;
          job_d.base         = '0;
          mag_d = col_new[ColIdxBits-1] ? col_neg[MagBits-1:0] : col_new[MagBits-1:0];
          neg_d = col_new[ColIdxBits-1];
          div_d = (cfg_i.wrap == WRAP_BOUNCE) ? (({1'b0, cfg_i.cols} << 1) - 12'd2)
                                              : {1'b0, cfg_i.cols};
          rem_d = '0;
          cnt_d = 5'(MagBits - 1);
          state_d = need_div ? F_DIV : F_PUSH;
        end
      end
      F_DIV: begin
        rem_d = rem_n;
        mag_d = mag_q << 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          job_d.base = base_w[ColCntBits-1:0];
          state_d    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule

### hdl/wtl_fifo.sv
`timescale 1ns / 1ps

module wtl_fifo import wtl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wtl_job_t wdata_i,
  input  logic     wvalid_i,
  output logic     wready_o,
  output wtl_job_t rdata_o,
  output logic     rvalid_o,
  input  logic     rready_i
);

  wtl_job_t   slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_w, do_r;

  assign wready_o = (cnt_q != 2'd2);
  assign rvalid_o = (cnt_q != 2'd0);
  assign rdata_o  = slot_q[rptr_q];
  assign do_w     = wvalid_i && wready_o;
  assign do_r     = rready_i && rvalid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_w) wptr_q <= ~wptr_q;
      if (do_r) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_w} - {1'b0, do_r};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_w) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/wtl_back.sv
`timescale 1ns / 1ps

module wtl_back import wtl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wtl_cfg_t cfg_i,
  input  wtl_job_t job_i,
  input  logic     job_valid_i,
  output logic     job_pop_o,
  output wtl_rsp_t rsp_o,
  output logic     empty,
  input  logic     pop
);

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_READ  = 6'b000010,
    B_DRAIN = 6'b000100,
    B_MUL1  = 6'b001000,
    B_MUL2  = 6'b010000,
    B_FIN   = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;

  logic signed [SampleBits-1:0] mem_q [2**AddrBits];
  logic signed [SampleBits-1:0] rdata_q;
  logic                         mem_we;
  logic [AddrBits-1:0]          raddr;

  wtl_job_t jq;
  logic [2:0] rd_q;
  logic [2:0] slot_q;
  logic       zero_q, rv_q;
  logic signed [SampleBits-1:0] smp_q [8];

  logic [1:0] step_q;
  logic       row_q, blend_q;
  logic signed [AccBits-1:0] acc_q, top_q, bot_q;
  logic signed [42:0]        phi_q;
  logic [31:0]               plo_q;
  logic                      out_valid_q;
  wtl_rsp_t                  rsp_q;

  // Column address for the current read.
  logic [2:0]               slot;
  logic                     rd_row;
  logic signed [2:0]        k;
  logic signed [19:0]       idx;
  logic signed [13:0]       cols_s, loop_s, u, u2, r_s;
  logic [ColBits-1:0]       cmap;
  logic                     zmap;
  logic                     cubic;
  logic [2:0]               rd_last;

  assign cubic   = (cfg_i.interp == INTERP_CUBIC);
  assign rd_last = cubic ? 3'd7 : 3'd3;
  assign slot    = cubic ? rd_q : {rd_q[1], rd_q[0], ~rd_q[0]};
  assign rd_row  = slot[2];
  assign k       = $signed({1'b0, slot[1:0]}) - 3'sd1;

  always_comb begin
    cols_s = $signed({3'b0, cfg_i.cols});
    loop_s = (cols_s <<< 1) - 14'sd2;
    idx    = 20'(jq.col) + 20'(k);
    u      = $signed({3'b0, jq.base}) + 14'(k);
    u2     = '0;
    r_s    = '0;
    cmap   = '0;
    zmap   = 1'b0;
    unique case (cfg_i.wrap)
      WRAP_WRAP: begin
        if (cfg_i.cols != 11'd1) begin
          if (u < 14'sd0)        u2 = u + cols_s;
          else if (u >= cols_s)  u2 = u - cols_s;
          else                   u2 = u;
          cmap = u2[ColBits-1:0];
        end
      end
      WRAP_BOUNCE: begin
        if (cfg_i.cols != 11'd1) begin
          if (u < 14'sd0)        u2 = u + loop_s;
          else if (u >= loop_s)  u2 = u - loop_s;
          else                   u2 = u;
          // A negative index mirrors the remainder of its magnitude.
          r_s = ((idx < 20'sd0) && (u2 != 14'sd0)) ? (loop_s - u2) : u2;
          if (r_s > (cols_s - 14'sd1)) r_s = loop_s - r_s;
          cmap = r_s[ColBits-1:0];
        end
      end
      WRAP_ZERO: begin
        zmap = (idx < 20'sd0) || (idx >= 20'(cols_s));
        cmap = idx[ColBits-1:0];
      end
      WRAP_CLAMP: begin
        if (idx < 20'sd0)               cmap = '0;
        else if (idx >= 20'(cols_s))    cmap = 10'(cfg_i.cols - 11'd1);
        else                            cmap = idx[ColBits-1:0];
      end
      default: cmap = '0;
    endcase
  end

  assign raddr  = {rd_row ? jq.row2 : jq.row1, cmap};
  assign mem_we = (state_q == B_IDLE) && job_valid_i && job_i.is_write;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[{job_i.entry_row, job_i.entry_column}] <= job_i.entry_value;
    end
    rdata_q <= mem_q[raddr];
  end

  // Interpolation arithmetic of the selected row.
  logic signed [16:0] ym, y0, y1, y2;
  logic signed [17:0] d0, d1, dl;
  logic signed [21:0] a, b, c;
  logic signed [AccBits-1:0] x, m, rowval, v, yv;
  logic signed [16:0] f;
  logic               last;

  assign ym = 17'(row_q ? smp_q[4] : smp_q[0]);
  assign y0 = 17'(row_q ? smp_q[5] : smp_q[1]);
  assign y1 = 17'(row_q ? smp_q[6] : smp_q[2]);
  assign y2 = 17'(row_q ? smp_q[7] : smp_q[3]);
  assign d0 = 18'(y1) - 18'(ym);
  assign d1 = 18'(y2) - 18'(y0);
  assign dl = 18'(y1) - 18'(y0);
  assign a  = 22'sd4 * (22'(y0) - 22'(y1)) + 22'(d0) + 22'(d1);
  assign b  = 22'sd6 * (22'(y1) - 22'(y0)) - 22'sd2 * 22'(d0) - 22'(d1);

  always_comb begin
    if (!cubic)               c = 22'(dl);
    else if (step_q == 2'd0)  c = a;
    else if (step_q == 2'd1)  c = b;
    else                      c = 22'(d0);
  end

  assign x = blend_q ? (bot_q - top_q)
                     : (((step_q == 2'd0) ? 42'sd0 : acc_q) + (42'(c) <<< FracBits));
  assign f = $signed({1'b0, blend_q ? jq.rr : jq.t});
  assign m = phi_q[AccBits-1:0] + $signed({26'd0, plo_q[31:16]});
  assign last   = cubic ? (step_q == 2'd2) : (step_q == 2'd0);
  assign rowval = (cubic ? m : (m <<< 1)) + (42'(y0) <<< 17);
  assign v      = top_q + acc_q;
  assign yv     = (v + 42'sd65536) >>> 17;

  assign job_pop_o = (state_q == B_IDLE) && job_valid_i;
  assign empty     = !out_valid_q;
  assign rsp_o     = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (job_valid_i && !job_i.is_write) state_d = B_READ;
      B_READ:  if (rd_q == rd_last) state_d = B_DRAIN;
      B_DRAIN: state_d = B_MUL1;
      B_MUL1:  state_d = B_MUL2;
      B_MUL2:  state_d = (blend_q) ? B_FIN : B_MUL1;
      B_FIN:   if (!out_valid_q || pop) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rd_q        <= '0;
      rv_q        <= 1'b0;
      step_q      <= '0;
      row_q       <= 1'b0;
      blend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == B_READ);
      if ((state_q == B_FIN) && (!out_valid_q || pop)) out_valid_q <= 1'b1;
      else if (pop && out_valid_q)                     out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          rd_q    <= '0;
          step_q  <= '0;
          row_q   <= 1'b0;
          blend_q <= 1'b0;
        end
        B_READ: rd_q <= rd_q + 3'd1;
        B_MUL2: begin
          if (!blend_q) begin
            if (!last) begin
              step_q <= step_q + 2'd1;
            end else if (!row_q) begin
              row_q  <= 1'b1;
              step_q <= '0;
            end else begin
              blend_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) jq <= job_i;
    slot_q <= slot;
    zero_q <= zmap;
    if (rv_q) smp_q[slot_q] <= zero_q ? '0 : rdata_q;
    if (state_q == B_MUL1) begin
      phi_q <= $signed(x[AccBits-1:FracBits]) * f;
      plo_q <= x[FracBits-1:0] * f[FracBits-1:0];
    end
    if (state_q == B_MUL2) begin
      acc_q <= m;
      if (!blend_q && last) begin
        if (row_q) bot_q <= rowval;
        else       top_q <= rowval;
      end
    end
    if ((state_q == B_FIN) && (!out_valid_q || pop)) begin
      if (yv > 42'sd32767) begin
        rsp_q.sample_out <= 16'sh7fff;
        rsp_q.saturated  <= 1'b1;
      end else if (yv < -42'sd32768) begin
        rsp_q.sample_out <= -16'sh8000;
        rsp_q.saturated  <= 1'b1;
      end else begin
        rsp_q.sample_out <= yv[SampleBits-1:0];
        rsp_q.saturated  <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE && job_valid_i && job_i.is_write) |=> (state_q == B_IDLE))
    else $error("table write left the idle state");
  a_lookup_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE && job_valid_i && !job_i.is_write) |=> (state_q == B_READ))
    else $error("lookup did not start reading");
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ) |-> (rd_q <= rd_last))
    else $error("read counter beyond the last read");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_FIN && out_valid_q && !pop) |=> (state_q == B_FIN))
    else $error("result overwritten before it was taken");
`endif

endmodule

### hdl/wavetable_2d_interpolated_lookup.sv
`timescale 1ns / 1ps

// Two-dimensional wavetable lookup with column and row interpolation.
// Requests enter through push/full: a request is taken when push is high and
// full is low. A table write request stores one sample and gives no result; a
// lookup request gives exactly one result on rsp_o, taken with pop while empty
// is low. Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i
// only while the block is idle: the user must keep to this, the block itself
// does not enforce it. The front end takes a new request only after handing
// the last one on to the queue; a lookup in wrap or bounce mode with more
// than one column first passes a serial remainder unit that resolves one bit
// of the column index per cycle. The back end's pace is set by the single
// table read port (up to eight reads) and the shared multiply step. A
// two-entry queue sits between them. Reset returns the control state to idle
// and sets the configuration to its defaults; table contents are undefined
// until written. When the receiver stalls the finished result is held, the
// back end waits, and full stays high once the queue has filled.

module wavetable_2d_interpolated_lookup import wtl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  wtl_req_t              req_i,
  output logic                  empty,
  input  logic                  pop,
  output wtl_rsp_t              rsp_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [ColCntBits-1:0] cfg_data_i
);

  interp_e               interp_q;
  wrap_e                 wrap_q;
  logic [RowCntBits-1:0] rows_q;
  logic [ColCntBits-1:0] cols_q;
  wtl_cfg_t              cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= INTERP_LINEAR;
      wrap_q   <= WRAP_WRAP;
      rows_q   <= 5'd1;
      cols_q   <= ColsMax;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_INTERP: interp_q <= interp_e'(cfg_data_i[0]);
        REG_WRAP:   wrap_q   <= wrap_e'(cfg_data_i[1:0]);
        REG_ROWS:   rows_q   <= cfg_data_i[RowCntBits-1:0];
        REG_COLS:   cols_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A count of zero behaves as one, a count above the table as the table size.
  always_comb begin
    cfg.interp = interp_q;
    cfg.wrap   = wrap_q;
    if (rows_q == '0)         cfg.rows = 5'd1;
    else if (rows_q > RowsMax) cfg.rows = RowsMax;
    else                      cfg.rows = rows_q;
    if (cols_q == '0)         cfg.cols = 11'd1;
    else if (cols_q > ColsMax) cfg.cols = ColsMax;
    else                      cfg.cols = cols_q;
  end

  wtl_job_t f_job, q_job;
  logic     f_valid, f_ready, q_valid, q_pop;

  wtl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  wtl_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wdata_i  (f_job),
    .wvalid_i (f_valid),
    .wready_o (f_ready),
    .rdata_o  (q_job),
    .rvalid_o (q_valid),
    .rready_i (q_pop)
  );

  wtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .rsp_o       (rsp_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
